// ===== hdl/rbst_pkg.sv =====
// shared types and constants of the ray versus box slab test
package rbst_pkg;

    localparam int AXES_DEF      = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CARRIED_AXES  = 3;

    localparam int COORD_W    = 32;
    localparam int LIMIT_W    = 31;
    localparam int DIST_W     = 64;
    localparam int DIST_FRAC  = 32;
    localparam int SCALE_W    = 18;
    localparam int SCALE_FRAC = 16;
    localparam int HALF_W     = DIST_W / 2;
    localparam int PART_W     = HALF_W + SCALE_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIST_W-1:0]  t_dist;

    localparam t_dist DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
    localparam t_dist DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

    typedef struct packed {
        t_dist              enter;
        logic [LIMIT_W-1:0] limit;
    } t_side;

endpackage

// ===== hdl/rbst_if.sv =====
// handshake channels of the slab test: request, response and configuration

interface rbst_req_if;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    rbst_pkg::t_coord      point_a_x;
    rbst_pkg::t_coord      point_a_y;
    rbst_pkg::t_coord      point_a_z;
    rbst_pkg::t_coord      point_b_x;
    rbst_pkg::t_coord      point_b_y;
    rbst_pkg::t_coord      point_b_z;
    logic [rbst_pkg::LIMIT_W-1:0] ray_limit;

    modport source (output valid, req_type, point_a_x, point_a_y, point_a_z,
                    point_b_x, point_b_y, point_b_z, ray_limit, input ready);
    modport sink   (input valid, req_type, point_a_x, point_a_y, point_a_z,
                    point_b_x, point_b_y, point_b_z, ray_limit, output ready);
endinterface

interface rbst_rsp_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

interface rbst_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rbst_pkg::SCALE_W-1:0]  exit_error_scale;

    modport source (output valid, exit_error_scale, input ready);
    modport sink   (input valid, exit_error_scale, output ready);
endinterface

// ===== hdl/rbst_lane.sv =====
// one axis lane: slab products, move to q32.32 and swap on negative reciprocal
module rbst_lane #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  rbst_pkg::t_coord i_pt_a,
    input  rbst_pkg::t_coord i_pt_b,
    input  rbst_pkg::t_coord i_org,
    input  rbst_pkg::t_coord i_rcp,
    output rbst_pkg::t_dist  o_enter,
    output rbst_pkg::t_dist  o_exit
);

    localparam int SHL = (2*FRAC_BITS < rbst_pkg::DIST_FRAC) ?
                         rbst_pkg::DIST_FRAC - 2*FRAC_BITS : 0;
    localparam int SHR = (2*FRAC_BITS >= rbst_pkg::DIST_FRAC) ?
                         2*FRAC_BITS - rbst_pkg::DIST_FRAC : 0;
    localparam int PROD_W = rbst_pkg::DIST_W + 1;

    function automatic rbst_pkg::t_dist to_dist(input rbst_pkg::t_dist p);
        logic [SHL:0] top;
        top = p[rbst_pkg::DIST_W-1 -: SHL+1];
        if (SHL == 0) begin
            return p >>> SHR;
        end else if ((&top) || !(|top)) begin
            return p <<< SHL;
        end else begin
            return p[rbst_pkg::DIST_W-1] ? rbst_pkg::DIST_MIN : rbst_pkg::DIST_MAX;
        end
    endfunction

    logic signed [rbst_pkg::COORD_W:0]   diff_a;
    logic signed [rbst_pkg::COORD_W:0]   diff_b;
    logic signed [rbst_pkg::DIST_W:0]    prod_a;
    logic signed [rbst_pkg::DIST_W:0]    prod_b;
    rbst_pkg::t_dist                     r_prod_a;
    rbst_pkg::t_dist                     r_prod_b;
    logic                                r_neg;
    rbst_pkg::t_dist                     dist_a;
    rbst_pkg::t_dist                     dist_b;
    rbst_pkg::t_dist                     r_enter;
    rbst_pkg::t_dist                     r_exit;

    assign diff_a = $signed({i_pt_a[rbst_pkg::COORD_W-1], i_pt_a})
                  - $signed({i_org[rbst_pkg::COORD_W-1], i_org});
    assign diff_b = $signed({i_pt_b[rbst_pkg::COORD_W-1], i_pt_b})
                  - $signed({i_org[rbst_pkg::COORD_W-1], i_org});
    assign prod_a = PROD_W'(diff_a) * PROD_W'(i_rcp);
    assign prod_b = PROD_W'(diff_b) * PROD_W'(i_rcp);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_a <= prod_a[rbst_pkg::DIST_W-1:0];
            r_prod_b <= prod_b[rbst_pkg::DIST_W-1:0];
            r_neg    <= i_rcp[rbst_pkg::COORD_W-1];
        end
    end

    assign dist_a = to_dist(r_prod_a);
    assign dist_b = to_dist(r_prod_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_enter <= r_neg ? dist_b : dist_a;
            r_exit  <= r_neg ? dist_a : dist_b;
        end
    end

    assign o_enter = r_enter;
    assign o_exit  = r_exit;

endmodule

// ===== hdl/rbst_merge.sv =====
// merge of the lanes: largest entry and smallest exit
module rbst_merge #(
    parameter int LANES = rbst_pkg::AXES_DEF
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbst_pkg::t_dist i_enter [LANES],
    input  rbst_pkg::t_dist i_exit  [LANES],
    output rbst_pkg::t_dist o_enter,
    output rbst_pkg::t_dist o_exit
);

    rbst_pkg::t_dist enter_max;
    rbst_pkg::t_dist exit_min;
    rbst_pkg::t_dist r_enter;
    rbst_pkg::t_dist r_exit;

    always_comb begin
        enter_max = rbst_pkg::DIST_MIN;
        exit_min  = rbst_pkg::DIST_MAX;
        for (int l = 0; l < LANES; l++) begin
            if (i_enter[l] > enter_max) begin
                enter_max = i_enter[l];
            end
            if (i_exit[l] < exit_min) begin
                exit_min = i_exit[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_enter <= enter_max;
            r_exit  <= exit_min;
        end
    end

    assign o_enter = r_enter;
    assign o_exit  = r_exit;

endmodule

// ===== hdl/rbst_scale.sv =====
// exit scaling by the q2.16 safety factor, split into two partial products
module rbst_scale (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  rbst_pkg::t_dist               i_exit,
    input  rbst_pkg::t_side               i_side,
    input  logic [rbst_pkg::SCALE_W-1:0]  i_scale,
    output rbst_pkg::t_dist               o_exit,
    output rbst_pkg::t_side               o_side
);

    localparam int DW  = rbst_pkg::DIST_W;
    localparam int HW  = rbst_pkg::HALF_W;
    localparam int PW  = rbst_pkg::PART_W;
    localparam int SF  = rbst_pkg::SCALE_FRAC;
    localparam int QW  = PW + SF;
    localparam int SAT = DW - 1 - SF;

    // magnitude stage
    logic [DW-1:0]     r_mag;
    logic              r_neg4;
    rbst_pkg::t_side   r_side4;
    // partial product stage
    logic [PW-1:0]     r_hi;
    logic [PW-1:0]     r_lo;
    logic              r_neg5;
    rbst_pkg::t_side   r_side5;
    // sum stage
    logic [QW-1:0]     sum;
    logic [QW-1:0]     r_q;
    logic              r_sat;
    logic              r_neg6;
    rbst_pkg::t_side   r_side6;
    // saturate stage
    rbst_pkg::t_dist   res;
    rbst_pkg::t_dist   r_res;
    rbst_pkg::t_side   r_side7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg4  <= i_exit[DW-1];
            r_mag   <= i_exit[DW-1] ? DW'(-i_exit) : DW'(i_exit);
            r_side4 <= i_side;

            r_hi    <= PW'(r_mag[DW-1:HW]) * PW'(i_scale);
            r_lo    <= PW'(r_mag[HW-1:0]) * PW'(i_scale);
            r_neg5  <= r_neg4;
            r_side5 <= r_side4;

            r_q     <= sum;
            r_sat   <= |r_hi[PW-1:SAT];
            r_neg6  <= r_neg5;
            r_side6 <= r_side5;

            r_res   <= res;
            r_side7 <= r_side6;
        end
    end

    // round away from zero on the magnitude for a negative exit
    assign sum = {r_hi, {SF{1'b0}}} + QW'(r_lo[PW-1:SF])
               + QW'(r_neg5 && (|r_lo[SF-1:0]));

    always_comb begin
        if (r_sat) begin
            res = r_neg6 ? rbst_pkg::DIST_MIN : rbst_pkg::DIST_MAX;
        end else if (|r_q[QW-1:DW-1]) begin
            res = r_neg6 ? rbst_pkg::DIST_MIN : rbst_pkg::DIST_MAX;
        end else if (r_neg6) begin
            res = -$signed(r_q[DW-1:0]);
        end else begin
            res = $signed(r_q[DW-1:0]);
        end
    end

    assign o_exit = r_res;
    assign o_side = r_side7;

endmodule

// ===== hdl/ray_box_slab_test.sv =====
// top level of the ray versus axis-aligned box slab test
//
//  channel  | dir | payload                                   | note
//  i_req    | in  | req_type, point_a_x..z, point_b_x..z,     | load ray or test box
//           |     | ray_limit                                 |
//  o_rsp    | out | hit                                       | one item per test
//  i_cfg    | in  | exit_error_scale                          | always ready
//
//  one item per cycle unless o_rsp stalls; a test answers once it has passed the
//  lane multipliers, the lane merge, the split exit scaling and the hit register
//  a load updates the ray at once and gives no item
//  reset is synchronous, active low; clears the ray and sets the scale to 1.0
//  a stalled o_rsp freezes the whole pipeline and drops i_req.ready
module ray_box_slab_test #(
    parameter int AXES      = rbst_pkg::AXES_DEF,
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbst_req_if.sink    i_req,
    rbst_rsp_if.source  o_rsp,
    rbst_cfg_if.sink    i_cfg
);

    localparam int USED  = (AXES < rbst_pkg::CARRIED_AXES) ? AXES : rbst_pkg::CARRIED_AXES;
    localparam int NA    = rbst_pkg::CARRIED_AXES;
    localparam int DEPTH = 7;
    localparam int LIMSH = rbst_pkg::DIST_FRAC - FRAC_BITS;

    rbst_pkg::t_coord                r_org [NA];
    rbst_pkg::t_coord                r_rcp [NA];
    logic [rbst_pkg::LIMIT_W-1:0]    r_lim;
    logic [rbst_pkg::SCALE_W-1:0]    r_scale;
    logic [rbst_pkg::LIMIT_W-1:0]    r_lim_d [3];
    logic [DEPTH-1:0]                r_vld;
    logic                            r_out_valid;
    logic                            r_hit;

    logic                            en;
    logic                            take;
    logic                            take_load;
    logic                            take_test;
    rbst_pkg::t_coord                pt_a [NA];
    rbst_pkg::t_coord                pt_b [NA];
    rbst_pkg::t_dist                 lane_enter [USED];
    rbst_pkg::t_dist                 lane_exit  [USED];
    rbst_pkg::t_dist                 m_enter;
    rbst_pkg::t_dist                 m_exit;
    rbst_pkg::t_side                 m_side;
    rbst_pkg::t_dist                 s_exit;
    rbst_pkg::t_side                 s_side;
    rbst_pkg::t_dist                 lim_q;
    logic                            hit;

    assign en        = !r_out_valid || o_rsp.ready;
    assign take      = i_req.valid && i_req.ready;
    assign take_load = take && (i_req.req_type == rbst_pkg::REQ_LOAD);
    assign take_test = take && (i_req.req_type == rbst_pkg::REQ_TEST);

    assign i_req.ready = en;
    assign i_cfg.ready = 1'b1;

    assign pt_a[0] = i_req.point_a_x;
    assign pt_a[1] = i_req.point_a_y;
    assign pt_a[2] = i_req.point_a_z;
    assign pt_b[0] = i_req.point_b_x;
    assign pt_b[1] = i_req.point_b_y;
    assign pt_b[2] = i_req.point_b_z;

    // ray state and scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_org[a] <= '0;
                r_rcp[a] <= '0;
            end
            r_lim   <= '0;
            r_scale <= rbst_pkg::SCALE_RESET;
        end else begin
            if (take_load) begin
                for (int a = 0; a < NA; a++) begin
                    r_org[a] <= pt_a[a];
                    r_rcp[a] <= pt_b[a];
                end
                r_lim <= i_req.ray_limit;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_scale <= i_cfg.exit_error_scale;
            end
        end
    end

    for (genvar g = 0; g < USED; g++) begin : g_lane
        rbst_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_pt_a  (pt_a[g]),
            .i_pt_b  (pt_b[g]),
            .i_org   (r_org[g]),
            .i_rcp   (r_rcp[g]),
            .o_enter (lane_enter[g]),
            .o_exit  (lane_exit[g])
        );
    end

    rbst_merge #(
        .LANES (USED)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_enter (lane_enter),
        .i_exit  (lane_exit),
        .o_enter (m_enter),
        .o_exit  (m_exit)
    );

    // limit follows the item through the lane and merge stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lim_d[0] <= r_lim;
            r_lim_d[1] <= r_lim_d[0];
            r_lim_d[2] <= r_lim_d[1];
        end
    end

    assign m_side = '{enter: m_enter, limit: r_lim_d[2]};

    rbst_scale u_scale (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_exit  (m_exit),
        .i_side  (m_side),
        .i_scale (r_scale),
        .o_exit  (s_exit),
        .o_side  (s_side)
    );

    assign lim_q = rbst_pkg::t_dist'(rbst_pkg::DIST_W'(s_side.limit) << LIMSH);
    assign hit   = (s_exit > 0) && (s_side.enter < s_exit) && (s_side.enter < lim_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[DEPTH-2:0], take_test};
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= hit;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.hit   = r_hit;

    a_test_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_test |=> r_vld[0])
        else $error("accepted test item did not enter the pipeline");

    a_load_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take_load || !take) && en |=> !r_vld[0])
        else $error("pipeline entry without a test item");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> $stable(r_vld) && r_out_valid)
        else $error("pipeline moved while the response was stalled");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[DEPTH-1]))
        else $error("response raised without an item in the last stage");

endmodule

// ===== tb/sv/rbst_slab_checker.sv =====
// checker for the slab test: predicts each hit item and compares it with the response
module rbst_slab_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rbst_req_if  i_req,
    rbst_rsp_if  i_rsp,
    rbst_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import rbst_pkg::*;

    localparam logic signed [83:0] WIDE_MAX = DIST_MAX;
    localparam logic signed [83:0] WIDE_MIN = DIST_MIN;

    t_coord               ray_org [CARRIED_AXES];
    t_coord               ray_rcp [CARRIED_AXES];
    logic [LIMIT_W-1:0]   ray_lim;
    logic [SCALE_W-1:0]   exit_scale;
    logic                 hit_q [$];
    int                   err_cnt;

    function automatic logic slab_hit(input t_coord low_c [CARRIED_AXES],
                                      input t_coord high_c [CARRIED_AXES]);
        t_dist                  enter_t;
        t_dist                  leave_t;
        t_dist                  near_t;
        t_dist                  far_t;
        t_dist                  swap_t;
        t_dist                  lim_t;
        logic signed [83:0]     scaled;
        int                     a;
        enter_t = DIST_MIN;
        leave_t = DIST_MAX;
        for (a = 0; a < CARRIED_AXES; a++) begin
            near_t = (t_dist'(low_c[a]) - t_dist'(ray_org[a])) * t_dist'(ray_rcp[a]);
            far_t  = (t_dist'(high_c[a]) - t_dist'(ray_org[a])) * t_dist'(ray_rcp[a]);
            if (ray_rcp[a] < 0) begin
                swap_t = near_t;
                near_t = far_t;
                far_t  = swap_t;
            end
            if (near_t > enter_t) enter_t = near_t;
            if (far_t < leave_t) leave_t = far_t;
        end
        // floor of exit times scale, then clamp to the distance range
        scaled = 84'(leave_t) * $signed({1'b0, exit_scale});
        scaled = scaled >>> SCALE_FRAC;
        if (scaled > WIDE_MAX) leave_t = DIST_MAX;
        else if (scaled < WIDE_MIN) leave_t = DIST_MIN;
        else leave_t = t_dist'(scaled);
        lim_t = t_dist'(ray_lim) <<< (DIST_FRAC - FRAC_BITS_DEF);
        return (leave_t > 0) && (enter_t < leave_t) && (enter_t < lim_t);
    endfunction

    always @(posedge i_clk) begin : watch
        t_coord lo_c [CARRIED_AXES];
        t_coord hi_c [CARRIED_AXES];
        logic   want_hit;
        if (!i_rst_n) begin
            for (int a = 0; a < CARRIED_AXES; a++) begin
                ray_org[a] = '0;
                ray_rcp[a] = '0;
            end
            ray_lim    = '0;
            exit_scale = SCALE_RESET;
            hit_q.delete();
            err_cnt    = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (hit_q.size() == 0) begin
                    $error("hit item with none expected, actual %0b", i_rsp.hit);
                    err_cnt++;
                end else begin
                    want_hit = hit_q.pop_front();
                    if (i_rsp.hit !== want_hit) begin
                        $error("hit mismatch: expected %0b, actual %0b", want_hit, i_rsp.hit);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) exit_scale = i_cfg.exit_error_scale;
            if (i_req.valid && i_req.ready) begin
                lo_c[0] = i_req.point_a_x;
                lo_c[1] = i_req.point_a_y;
                lo_c[2] = i_req.point_a_z;
                hi_c[0] = i_req.point_b_x;
                hi_c[1] = i_req.point_b_y;
                hi_c[2] = i_req.point_b_z;
                if (i_req.req_type == REQ_LOAD) begin
                    ray_org = lo_c;
                    ray_rcp = hi_c;
                    ray_lim = i_req.ray_limit;
                end else begin
                    hit_q.push_back(slab_hit(lo_c, hi_c));
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= hit_q.size();
    end

endmodule

// ===== tb/sv/tb_ray_box_slab_test.sv =====
// testbench top for the slab test: clock, reset, stimulus, idling and verdict
module tb_ray_box_slab_test;
    import rbst_pkg::*;

    localparam int     PIPE_DEPTH  = 8;
    localparam int     SETTLE      = PIPE_DEPTH + 4;
    localparam int     HOLD_CYCLES = 64;
    localparam int     IDLE_LIMIT  = 2000;
    localparam int     PHASES      = 6;
    localparam int     PHASE_ITEMS = 222;
    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_coord CMIN = 32'sh8000_0000;
    localparam t_coord CMAX = 32'sh7FFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIM_MAX = '1;

    typedef struct {
        logic               req_type;
        t_coord             pa [CARRIED_AXES];
        t_coord             pb [CARRIED_AXES];
        logic [LIMIT_W-1:0] lim;
    } ray_req_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    int     err_count;
    int     pending;
    int     send_idle_pct = 0;
    int     rsp_stall_pct = 0;
    int     hold_reqs = 0;
    int     hold_done = 0;
    int     idle_cycles = 0;
    t_coord cur_org [CARRIED_AXES];

    rbst_req_if req_ch ();
    rbst_rsp_if rsp_ch ();
    rbst_cfg_if cfg_ch ();

    ray_box_slab_test dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    rbst_slab_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (err_count),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_ray_box_slab_test failed");
            $finish;
        end
    end

    // receiver: random stalls plus the long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_done) begin
                hold_done++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            rsp_ch.ready <= !($urandom_range(99) < rsp_stall_pct);
        end
    end

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic ray_req_t ray_load(input t_coord ox, oy, oz, rx, ry, rz,
                                          input logic [LIMIT_W-1:0] lim);
        ray_req_t r;
        r.req_type = REQ_LOAD;
        r.pa = '{ox, oy, oz};
        r.pb = '{rx, ry, rz};
        r.lim = lim;
        return r;
    endfunction

    function automatic ray_req_t box_test(input t_coord lx, ly, lz, hx, hy, hz);
        ray_req_t r;
        r.req_type = REQ_TEST;
        r.pa = '{lx, ly, lz};
        r.pb = '{hx, hy, hz};
        r.lim = LIMIT_W'($urandom());
        return r;
    endfunction

    // mostly boxes near the current ray so that hits are common
    function automatic ray_req_t rand_req();
        ray_req_t r;
        int       roll;
        int       sel;
        t_coord   swap_c;
        roll = $urandom_range(99);
        if (roll < 18) begin
            r.req_type = REQ_LOAD;
            for (int a = 0; a < CARRIED_AXES; a++) begin
                if (roll < 13) begin
                    r.pa[a] = spread(1 << 21);
                    sel = $urandom_range(9);
                    if (sel == 0) r.pb[a] = '0;
                    else if (sel < 6) r.pb[a] = spread(1 << 18);
                    else r.pb[a] = $urandom();
                end else begin
                    r.pa[a] = $urandom();
                    r.pb[a] = $urandom();
                end
            end
            sel = $urandom_range(7);
            case (sel)
                0:       r.lim = '0;
                1:       r.lim = LIM_MAX;
                2, 3:    r.lim = LIMIT_W'($urandom_range(0, 1 << 24));
                default: r.lim = LIMIT_W'($urandom());
            endcase
            cur_org = r.pa;
        end else begin
            r.req_type = REQ_TEST;
            r.lim = LIMIT_W'($urandom());
            for (int a = 0; a < CARRIED_AXES; a++) begin
                if (roll < 92) begin
                    r.pa[a] = cur_org[a] + spread(1 << 21);
                    r.pb[a] = r.pa[a] + t_coord'($urandom_range(0, 1 << 21));
                    if ($urandom_range(9) == 0) begin
                        swap_c  = r.pa[a];
                        r.pa[a] = r.pb[a];
                        r.pb[a] = swap_c;
                    end
                end else begin
                    r.pa[a] = $urandom();
                    r.pb[a] = $urandom();
                end
            end
        end
        return r;
    endfunction

    task automatic send_req(input ray_req_t r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= r.req_type;
        req_ch.point_a_x <= r.pa[0];
        req_ch.point_a_y <= r.pa[1];
        req_ch.point_a_z <= r.pa[2];
        req_ch.point_b_x <= r.pb[0];
        req_ch.point_b_y <= r.pb[1];
        req_ch.point_b_z <= r.pb[2];
        req_ch.ray_limit <= r.lim;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.exit_error_scale <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic [SCALE_W-1:0] scale;
        i_rst_n                 = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.req_type         = REQ_LOAD;
        req_ch.point_a_x        = '0;
        req_ch.point_a_y        = '0;
        req_ch.point_a_z        = '0;
        req_ch.point_b_x        = '0;
        req_ch.point_b_y        = '0;
        req_ch.point_b_z        = '0;
        req_ch.ray_limit        = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.exit_error_scale = '0;
        cur_org                 = '{'0, '0, '0};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // test before any load, then unit rays both ways
        send_req(box_test(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_req(ray_load(0, 0, 0, ONE, ONE, ONE, LIM_MAX));
        send_req(box_test(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        send_req(box_test(-2 * ONE, -2 * ONE, -2 * ONE, -ONE, -ONE, -ONE));
        send_req(box_test(2 * ONE, 2 * ONE, 2 * ONE, ONE, ONE, ONE));
        send_req(box_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_req(ray_load(0, 0, 0, -ONE, -ONE, -ONE, LIM_MAX));
        send_req(box_test(-2 * ONE, -2 * ONE, -2 * ONE, -ONE, -ONE, -ONE));
        send_req(box_test(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        // zero reciprocal on one axis
        send_req(ray_load(0, 0, 0, 0, ONE, ONE, LIM_MAX));
        send_req(box_test(-ONE, ONE, ONE, ONE, 2 * ONE, 2 * ONE));
        // zero limit
        send_req(ray_load(0, 0, 0, ONE, ONE, ONE, '0));
        send_req(box_test(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        send_req(box_test(-ONE, -ONE, -ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        // field extremes
        send_req(ray_load(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, '0));
        send_req(box_test(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_req(box_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_req(ray_load(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, LIM_MAX));
        send_req(box_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_req(box_test(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
        send_req(ray_load(0, 0, 0, CMAX, CMIN, ONE, LIM_MAX));
        send_req(box_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       scale = '0;
                1:       scale = '1;
                2:       scale = SCALE_RESET;
                5:       scale = SCALE_W'($urandom_range(65536, 70000));
                default: scale = SCALE_W'($urandom());
            endcase
            write_scale(scale);
            case (ph)
                1: begin send_idle_pct = 84; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 84; end
                3: begin send_idle_pct = 8;  rsp_stall_pct = 8;  end
                5: begin send_idle_pct = 84; rsp_stall_pct = 84; end
                default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == 40) hold_reqs++;
                send_req(rand_req());
            end
        end

        drain();
        if (err_count == 0 && pending == 0) begin
            $display("tb_ray_box_slab_test passed");
        end else begin
            $display("tb_ray_box_slab_test failed");
        end
        $finish;
    end

endmodule
